FILE: design/cstok_pkg.sv
// Shared types and constants for the C subset token scanner.
// Token kind codes, scanner state encoding, result word layout.
// No dependencies.
package cstok_pkg;

	localparam int KindW = 7;
	localparam int ValW  = 64;
	localparam int LenW  = 8;
	localparam int NameKeep = 8;
	localparam int NumKw = 23;

	localparam logic [6:0] K_IDENT   = 7'd1;
	localparam logic [6:0] K_BLANK   = 7'd5;
	localparam logic [6:0] K_COMMA   = 7'd21;
	localparam logic [6:0] K_SEMI    = 7'd22;
	localparam logic [6:0] K_LPAR    = 7'd23;
	localparam logic [6:0] K_RPAR    = 7'd24;
	localparam logic [6:0] K_LBRK    = 7'd25;
	localparam logic [6:0] K_RBRK    = 7'd26;
	localparam logic [6:0] K_LBRC    = 7'd27;
	localparam logic [6:0] K_RBRC    = 7'd28;
	localparam logic [6:0] K_INC     = 7'd29;
	localparam logic [6:0] K_DEC     = 7'd30;
	localparam logic [6:0] K_TILDE   = 7'd31;
	localparam logic [6:0] K_NOT     = 7'd32;
	localparam logic [6:0] K_ADD     = 7'd33;
	localparam logic [6:0] K_SUB     = 7'd34;
	localparam logic [6:0] K_MUL     = 7'd35;
	localparam logic [6:0] K_DIV     = 7'd36;
	localparam logic [6:0] K_MOD     = 7'd37;
	localparam logic [6:0] K_SHL     = 7'd38;
	localparam logic [6:0] K_SHR     = 7'd39;
	localparam logic [6:0] K_LT      = 7'd40;
	localparam logic [6:0] K_GT      = 7'd41;
	localparam logic [6:0] K_LE      = 7'd42;
	localparam logic [6:0] K_GE      = 7'd43;
	localparam logic [6:0] K_EQ      = 7'd44;
	localparam logic [6:0] K_NE      = 7'd45;
	localparam logic [6:0] K_BAND    = 7'd46;
	localparam logic [6:0] K_LAND    = 7'd47;
	localparam logic [6:0] K_BOR     = 7'd48;
	localparam logic [6:0] K_LOR     = 7'd49;
	localparam logic [6:0] K_XOR     = 7'd50;
	localparam logic [6:0] K_QUES    = 7'd51;
	localparam logic [6:0] K_COLON   = 7'd52;
	localparam logic [6:0] K_ASGN    = 7'd53;
	localparam logic [6:0] K_INTC    = 7'd54;
	localparam logic [6:0] K_UINTC   = 7'd55;
	localparam logic [6:0] K_SHORTC  = 7'd56;
	localparam logic [6:0] K_USHORTC = 7'd57;
	localparam logic [6:0] K_LONGC   = 7'd58;
	localparam logic [6:0] K_ULONGC  = 7'd59;
	localparam logic [6:0] K_FLOATC  = 7'd60;
	localparam logic [6:0] K_DOUBLEC = 7'd61;
	localparam logic [6:0] K_CHARC   = 7'd62;
	localparam logic [6:0] K_STRC    = 7'd63;
	localparam logic [6:0] K_ADDEQ   = 7'd64;
	localparam logic [6:0] K_SUBEQ   = 7'd65;
	localparam logic [6:0] K_SHLEQ   = 7'd66;
	localparam logic [6:0] K_SHREQ   = 7'd67;
	localparam logic [6:0] K_MULEQ   = 7'd68;
	localparam logic [6:0] K_DIVEQ   = 7'd69;
	localparam logic [6:0] K_MODEQ   = 7'd70;
	localparam logic [6:0] K_END     = 7'd71;
	localparam logic [6:0] K_DOLLAR  = 7'd74;
	localparam logic [6:0] K_ERROR   = 7'd77;

	localparam logic [63:0] KW_WORD [NumKw] = '{
		64'h74736e6f63, 64'h666e616373, 64'h66746e697270, 64'h64656e676973,
		64'h64656e6769736e75, 64'h64696f76, 64'h72616863, 64'h6b61657262,
		64'h65756e69746e6f63, 64'h746e69, 64'h74726f6873, 64'h676e6f6c,
		64'h74616f6c66, 64'h656c62756f64, 64'h6669, 64'h65736c65,
		64'h686374697773, 64'h65736163, 64'h726f66, 64'h656c696877,
		64'h6f64, 64'h6e7275746572, 64'h4c4c554e
	};
	localparam logic [7:0] KW_LEN [NumKw] = '{
		8'd5, 8'd5, 8'd6, 8'd6, 8'd8, 8'd4, 8'd4, 8'd5, 8'd8, 8'd3, 8'd5, 8'd4,
		8'd5, 8'd6, 8'd2, 8'd4, 8'd6, 8'd4, 8'd3, 8'd5, 8'd2, 8'd6, 8'd4
	};
	localparam logic [6:0] KW_KIND [NumKw] = '{
		7'd0, 7'd2, 7'd3, 7'd6, 7'd7, 7'd8, 7'd14, 7'd72, 7'd73, 7'd10, 7'd9,
		7'd11, 7'd12, 7'd13, 7'd15, 7'd16, 7'd75, 7'd76, 7'd17, 7'd18, 7'd19,
		7'd20, 7'd4
	};

	typedef enum logic [23:0] {
		S_START  = 24'h000001, S_BLANK  = 24'h000002, S_IDENT  = 24'h000004,
		S_INT    = 24'h000008, S_UINT   = 24'h000010, S_DBL    = 24'h000020,
		S_CHOPEN = 24'h000040, S_CHESC  = 24'h000080, S_CHSKIP = 24'h000100,
		S_STR    = 24'h000200, S_STRESC = 24'h000400, S_PLUS   = 24'h000800,
		S_SUBT   = 24'h001000, S_NOT    = 24'h002000, S_MUL    = 24'h004000,
		S_DIV    = 24'h008000, S_MOD    = 24'h010000, S_LT     = 24'h020000,
		S_GT     = 24'h040000, S_SL     = 24'h080000, S_SR     = 24'h100000,
		S_ASGN   = 24'h200000, S_BAND   = 24'h400000, S_BOR    = 24'h800000
	} scan_st_t;

	typedef struct packed {
		logic [6:0]  kind;
		logic [63:0] value;
		logic [7:0]  len;
		logic        done;
	} res_t;

endpackage

FILE: design/c_subset_token_scanner_top.sv
// Top level of the C subset token scanner: byte in, tokens out.
// Uses cstok_pkg for kind codes, keyword table and state encoding.
//
// channel   dir  handshake           payload
// s_axis    in   tvalid/tready       tdata[7:0] byte, tlast last byte
// m_axis    out  tvalid/tready       tdata {name_length, value}, tuser {done, kind}
// cfg       in   cfg_wr_en           cfg_wr_data emit_blanks
//
// One byte is scanned per cycle while the buffer is free; a byte's 0..3 tokens
// are computed in one pass and drained from a three-slot result buffer at one
// token per cycle while m_axis_tready is high, and no byte is taken meanwhile.
// The next byte is taken in the cycle the last buffered token leaves.
// arst_n clears scanner state, the buffer and emit_blanks.
module c_subset_token_scanner_top
	import cstok_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] next_char
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,   // [63:0] token_value, [71:64] name_length
	output logic [7:0]  m_axis_tuser,   // [6:0] token_kind, [7] string_done
	output logic        m_axis_tlast,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data
);

	scan_st_t    st_q;
	logic [63:0] acc_q, name_q;
	logic [7:0]  cnt_q;
	logic        err_q, blanks_q;
	res_t        res_q [3];
	logic [1:0]  num_q, rd_q;

	logic [7:0] c;
	logic       s_acc, m_acc;
	assign c = s_axis_tdata;

	function automatic logic [6:0] kw_kind(input logic [63:0] nm, input logic [7:0] n);
		logic [6:0] k;
		k = K_IDENT;
		for (int i = 0; i < NumKw; i++)
			if (KW_LEN[i] == n && KW_WORD[i] == nm) k = KW_KIND[i];
		return k;
	endfunction

	function automatic res_t mk(input logic [6:0] k, input logic [63:0] v,
			input logic [7:0] l, input logic d);
		res_t r;
		r.kind = k; r.value = v; r.len = l; r.done = d;
		return r;
	endfunction

	function automatic logic [7:0] unesc(input logic [7:0] x);
		logic [7:0] y;
		unique case (x)
			8'h61: y = 8'd7;
			8'h62: y = 8'd8;
			8'h74: y = 8'd9;
			8'h76: y = 8'd11;
			8'h66: y = 8'd12;
			8'h6e: y = 8'd10;
			8'h72: y = 8'd13;
			default: y = x;
		endcase
		return y;
	endfunction

	typedef struct packed {
		logic [6:0] alone;
		logic       dch_v;
		logic [7:0] dch;
		logic       dk_v;
		logic [6:0] dk;
		logic       eq_v;
		logic [6:0] eq;
	} op_t;

	function automatic op_t op_info(input scan_st_t s);
		op_t o;
		o = '0;
		unique case (s)
			S_PLUS: o = '{K_ADD, 1'b1, 8'h2b, 1'b1, K_INC, 1'b1, K_ADDEQ};
			S_SUBT: o = '{K_SUB, 1'b1, 8'h2d, 1'b1, K_DEC, 1'b1, K_SUBEQ};
			S_NOT:  o = '{K_NOT, 1'b0, 8'h00, 1'b0, K_NOT, 1'b1, K_NE};
			S_MUL:  o = '{K_MUL, 1'b0, 8'h00, 1'b0, K_MUL, 1'b1, K_MULEQ};
			S_DIV:  o = '{K_DIV, 1'b0, 8'h00, 1'b0, K_DIV, 1'b1, K_DIVEQ};
			S_MOD:  o = '{K_MOD, 1'b0, 8'h00, 1'b0, K_MOD, 1'b1, K_MODEQ};
			S_LT:   o = '{K_LT, 1'b1, 8'h3c, 1'b0, K_LT, 1'b1, K_LE};
			S_GT:   o = '{K_GT, 1'b1, 8'h3e, 1'b0, K_GT, 1'b1, K_GE};
			S_SL:   o = '{K_SHL, 1'b0, 8'h00, 1'b0, K_SHL, 1'b1, K_SHLEQ};
			S_SR:   o = '{K_SHR, 1'b0, 8'h00, 1'b0, K_SHR, 1'b1, K_SHREQ};
			S_ASGN: o = '{K_ASGN, 1'b0, 8'h00, 1'b0, K_ASGN, 1'b1, K_EQ};
			S_BAND: o = '{K_BAND, 1'b1, 8'h26, 1'b1, K_LAND, 1'b0, K_BAND};
			S_BOR:  o = '{K_BOR, 1'b1, 8'h7c, 1'b1, K_LOR, 1'b0, K_BOR};
			default: o = '0;
		endcase
		return o;
	endfunction

	// start of a new token from byte c
	logic       is_dig, is_alp, is_blk;
	scan_st_t   sst;
	logic       sput_v, serr;
	res_t       sput;

	always_comb begin
		is_dig = c >= 8'h30 && c <= 8'h39;
		is_alp = (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
		is_blk = c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
		sst = S_START;
		sput_v = 1'b1;
		serr = 1'b0;
		sput = mk(K_ERROR, 64'd0, 8'd0, 1'b0);
		if (is_dig) begin
			sst = S_INT; sput_v = 1'b0;
		end else if (is_alp || c == 8'h5f) begin
			sst = S_IDENT; sput_v = 1'b0;
		end else if (is_blk) begin
			sst = S_BLANK; sput_v = 1'b0;
		end else begin
			unique case (c)
				8'h27: begin sst = S_CHOPEN; sput_v = 1'b0; end
				8'h22: begin sst = S_STR; sput_v = 1'b0; end
				8'h2b: begin sst = S_PLUS; sput_v = 1'b0; end
				8'h2d: begin sst = S_SUBT; sput_v = 1'b0; end
				8'h21: begin sst = S_NOT; sput_v = 1'b0; end
				8'h2a: begin sst = S_MUL; sput_v = 1'b0; end
				8'h2f: begin sst = S_DIV; sput_v = 1'b0; end
				8'h25: begin sst = S_MOD; sput_v = 1'b0; end
				8'h3c: begin sst = S_LT; sput_v = 1'b0; end
				8'h3e: begin sst = S_GT; sput_v = 1'b0; end
				8'h3d: begin sst = S_ASGN; sput_v = 1'b0; end
				8'h26: begin sst = S_BAND; sput_v = 1'b0; end
				8'h7c: begin sst = S_BOR; sput_v = 1'b0; end
				8'h7e: sput.kind = K_TILDE;
				8'h24: sput.kind = K_DOLLAR;
				8'h28: sput.kind = K_LPAR;
				8'h29: sput.kind = K_RPAR;
				8'h5b: sput.kind = K_LBRK;
				8'h5d: sput.kind = K_RBRK;
				8'h7b: sput.kind = K_LBRC;
				8'h7d: sput.kind = K_RBRC;
				8'h2c: sput.kind = K_COMMA;
				8'h3b: sput.kind = K_SEMI;
				8'h3f: sput.kind = K_QUES;
				8'h3a: sput.kind = K_COLON;
				8'h5e: sput.kind = K_XOR;
				default: begin sput.value = {56'd0, c}; serr = 1'b1; end
			endcase
		end
	end

	// one pass: feed, start, flush, end
	scan_st_t    nst;
	logic [63:0] nacc, nname;
	logic [7:0]  ncnt;
	logic        nerr, do_st, fput_v, lput_v;
	res_t        fput, lput;
	op_t         op, lop;
	res_t        cand [4];
	logic [3:0]  cv;
	res_t        r [3];
	logic [2:0]  n;

	always_comb begin
		nst = st_q; nacc = acc_q; nname = name_q; ncnt = cnt_q; nerr = err_q;
		do_st = 1'b0; fput_v = 1'b0; fput = mk(K_END, 64'd0, 8'd0, 1'b0);
		op = op_info(st_q);
		if (!err_q) begin
			unique case (st_q)
				S_START: do_st = 1'b1;
				S_BLANK: if (!is_blk) begin
					fput_v = blanks_q; fput.kind = K_BLANK; do_st = 1'b1;
				end
				S_IDENT: if (is_alp || is_dig || c == 8'h5f) begin
					if (cnt_q < 8'(NameKeep))
						nname = name_q | ({56'd0, c} << {cnt_q[2:0], 3'b000});
					if (cnt_q != 8'hff) ncnt = cnt_q + 8'd1;
				end else begin
					fput_v = 1'b1;
					fput = mk(kw_kind(name_q, cnt_q), name_q, cnt_q, 1'b0);
					do_st = 1'b1;
				end
				S_INT: begin
					if (is_dig)
						nacc = (acc_q << 3) + (acc_q << 1) + {60'd0, c[3:0]};
					else if (c == 8'h2e) nst = S_DBL;
					else if (c == 8'h75) nst = S_UINT;
					else begin
						nst = S_START; fput_v = 1'b1;
						priority if (c == 8'h6c) fput = mk(K_LONGC, acc_q, 8'd0, 1'b0);
						else if (c == 8'h73)
							fput = mk(K_SHORTC, {48'd0, acc_q[15:0]}, 8'd0, 1'b0);
						else if (c == 8'h66) fput.kind = K_FLOATC;
						else if (c == 8'h64) fput.kind = K_DOUBLEC;
						else begin
							fput = mk(K_INTC, {32'd0, acc_q[31:0]}, 8'd0, 1'b0);
							do_st = 1'b1;
						end
					end
				end
				S_UINT: begin
					nst = S_START; fput_v = 1'b1;
					priority if (c == 8'h6c) fput = mk(K_ULONGC, acc_q, 8'd0, 1'b0);
					else if (c == 8'h73)
						fput = mk(K_USHORTC, {48'd0, acc_q[15:0]}, 8'd0, 1'b0);
					else begin
						fput = mk(K_UINTC, {32'd0, acc_q[31:0]}, 8'd0, 1'b0);
						do_st = 1'b1;
					end
				end
				S_DBL: if (!is_dig) begin
					nst = S_START; fput_v = 1'b1;
					if (c == 8'h66) fput.kind = K_FLOATC;
					else begin fput.kind = K_DOUBLEC; do_st = 1'b1; end
				end
				S_CHOPEN: if (c == 8'h5c) nst = S_CHESC;
				else begin
					fput_v = 1'b1; fput = mk(K_CHARC, {56'd0, c}, 8'd0, 1'b0);
					nst = S_CHSKIP;
				end
				S_CHESC: begin
					fput_v = 1'b1; fput = mk(K_CHARC, {56'd0, unesc(c)}, 8'd0, 1'b0);
					nst = S_CHSKIP;
				end
				S_CHSKIP: nst = S_START;
				S_STR: begin
					priority if (c == 8'h5c) nst = S_STRESC;
					else if (c == 8'h22) begin
						fput_v = 1'b1; fput = mk(K_STRC, 64'd0, 8'd0, 1'b1); nst = S_START;
					end else begin
						fput_v = 1'b1; fput = mk(K_STRC, {56'd0, c}, 8'd0, 1'b0);
					end
				end
				S_STRESC: begin
					fput_v = 1'b1; fput = mk(K_STRC, {56'd0, unesc(c)}, 8'd0, 1'b0);
					nst = S_STR;
				end
				default: begin
					nst = S_START;
					priority if (op.dch_v && c == op.dch) begin
						if (st_q == S_LT) nst = S_SL;
						else if (st_q == S_GT) nst = S_SR;
						else begin fput_v = op.dk_v; fput.kind = op.dk; end
					end else if (c == 8'h3d && op.eq_v) begin
						fput_v = 1'b1; fput.kind = op.eq;
					end else begin
						fput_v = 1'b1; fput.kind = op.alone; do_st = 1'b1;
					end
				end
			endcase
		end
		if (do_st) begin
			nst = sst;
			nerr = serr;
			if (is_dig) nacc = {60'd0, c[3:0]};
			if (is_alp || c == 8'h5f) begin nname = {56'd0, c}; ncnt = 8'd1; end
		end

		lput_v = 1'b0; lput = mk(K_END, 64'd0, 8'd0, 1'b0);
		lop = op_info(nst);
		if (s_axis_tlast && !nerr) begin
			unique case (nst)
				S_BLANK: begin lput_v = blanks_q; lput.kind = K_BLANK; end
				S_IDENT: begin
					lput_v = 1'b1; lput = mk(kw_kind(nname, ncnt), nname, ncnt, 1'b0);
				end
				S_INT: begin
					lput_v = 1'b1; lput = mk(K_INTC, {32'd0, nacc[31:0]}, 8'd0, 1'b0);
				end
				S_UINT: begin
					lput_v = 1'b1; lput = mk(K_UINTC, {32'd0, nacc[31:0]}, 8'd0, 1'b0);
				end
				S_DBL: begin lput_v = 1'b1; lput.kind = K_DOUBLEC; end
				S_CHOPEN, S_CHESC: begin lput_v = 1'b1; lput.kind = K_ERROR; end
				S_STR, S_STRESC: begin
					lput_v = 1'b1; lput = mk(K_STRC, 64'd0, 8'd0, 1'b1);
				end
				S_START, S_CHSKIP: lput_v = 1'b0;
				default: begin lput_v = 1'b1; lput.kind = lop.alone; end
			endcase
		end

		cand[0] = fput; cand[1] = sput; cand[2] = lput;
		cand[3] = mk(K_END, 64'd0, 8'd0, 1'b0);
		cv = {s_axis_tlast, lput_v, do_st & sput_v, fput_v};
		n = 3'd0;
		for (int i = 0; i < 3; i++) r[i] = cand[3];
		for (int i = 0; i < 4; i++)
			if (cv[i] && n < 3'd3) begin
				r[n[1:0]] = cand[i];
				n = n + 3'd1;
			end
	end

	assign m_axis_tvalid = rd_q != num_q;
	assign m_acc = m_axis_tvalid && m_axis_tready;
	assign s_axis_tready = !m_axis_tvalid || (m_acc && (rd_q + 2'd1 == num_q));
	assign s_acc = s_axis_tvalid && s_axis_tready;
	assign m_axis_tdata = {res_q[rd_q].len, res_q[rd_q].value};
	assign m_axis_tuser = {res_q[rd_q].done, res_q[rd_q].kind};
	assign m_axis_tlast = rd_q + 2'd1 == num_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_START; acc_q <= '0; name_q <= '0; cnt_q <= '0; err_q <= 1'b0;
			blanks_q <= 1'b0; num_q <= '0; rd_q <= '0;
		end else begin
			if (cfg_wr_en) blanks_q <= cfg_wr_data;
			if (s_acc) begin
				num_q <= n[1:0];
				rd_q <= '0;
				if (s_axis_tlast) begin
					st_q <= S_START; acc_q <= '0; name_q <= '0; cnt_q <= '0;
					err_q <= 1'b0;
				end else begin
					st_q <= nst; acc_q <= nacc; name_q <= nname; cnt_q <= ncnt;
					err_q <= nerr;
				end
			end else if (m_acc) begin
				rd_q <= rd_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc)
			for (int i = 0; i < 3; i++) res_q[i] <= r[i];
	end

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the C subset token scanner top level.
// Drives bytes with random gaps, predicts tokens per byte, compares in order.
// Depends on cstok_pkg and c_subset_token_scanner_top.
module testbench;
	import cstok_pkg::*;

	typedef struct {
		logic [6:0]  kind;
		logic [63:0] value;
		logic [7:0]  len;
		logic        done;
		logic        last;
	} token_t;

	typedef struct {
		logic [7:0] ch;
		logic       lst;
		logic       chk;
		logic [6:0] kind;
		logic [63:0] value;
	} stim_row_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 0;
	logic        s_axis_tlast = 0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [71:0] m_axis_tdata;
	logic [7:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_wr_en = 0;
	logic        cfg_wr_data = 0;

	c_subset_token_scanner_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	// scanner shadow state
	scan_st_t    sc_state;
	logic [63:0] sc_acc;
	logic [63:0] sc_name;
	logic [7:0]  sc_count;
	logic        sc_err;
	logic        sc_blanks;

	token_t      byte_toks[$];
	token_t      token_queue[$];
	int          mismatches = 0;
	int          cycles = 0;
	int          rx_wait = 0;
	bit          hold_off = 0;
	bit          check_next = 0;
	logic [6:0]  check_kind;
	logic [63:0] check_value;

	function automatic bit is_blank(logic [7:0] c);
		return c == 8'h20 || c == 8'h09 || c == 8'h0b || c == 8'h0c || c == 8'h0a ||
			c == 8'h0d;
	endfunction

	function automatic bit is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_alpha(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic [7:0] unescape(logic [7:0] c);
		case (c)
			"a": return 8'd7;
			"b": return 8'd8;
			"t": return 8'd9;
			"v": return 8'd11;
			"f": return 8'd12;
			"n": return 8'd10;
			"r": return 8'd13;
			default: return c;
		endcase
	endfunction

	task automatic push_tok(logic [6:0] k, logic [63:0] v, logic [7:0] l, logic d);
		token_t t;
		t.kind = k; t.value = v; t.len = l; t.done = d; t.last = 0;
		if (byte_toks.size() < 3)
			byte_toks.insert(byte_toks.size(), t);
	endtask

	task automatic push_ident();
		logic [6:0] k;
		k = K_IDENT;
		for (int i = 0; i < NumKw; i++) begin
			if (KW_LEN[i] == sc_count && KW_WORD[i] == sc_name) begin
				k = KW_KIND[i];
				break;
			end
		end
		push_tok(k, sc_name, sc_count, 0);
	endtask

	task automatic op_parts(scan_st_t s, output logic [6:0] alone, output logic [8:0] dch,
			output logic [6:0] dk, output logic [6:0] eqk, output bit has_eq);
		has_eq = 1; dch = 9'h100; dk = K_ERROR; eqk = K_ERROR;
		case (s)
			S_PLUS: begin alone = K_ADD; dch = "+"; dk = K_INC; eqk = K_ADDEQ; end
			S_SUBT: begin alone = K_SUB; dch = "-"; dk = K_DEC; eqk = K_SUBEQ; end
			S_NOT:  begin alone = K_NOT; eqk = K_NE; end
			S_MUL:  begin alone = K_MUL; eqk = K_MULEQ; end
			S_DIV:  begin alone = K_DIV; eqk = K_DIVEQ; end
			S_MOD:  begin alone = K_MOD; eqk = K_MODEQ; end
			S_LT:   begin alone = K_LT; dch = "<"; eqk = K_LE; end
			S_GT:   begin alone = K_GT; dch = ">"; eqk = K_GE; end
			S_SL:   begin alone = K_SHL; eqk = K_SHLEQ; end
			S_SR:   begin alone = K_SHR; eqk = K_SHREQ; end
			S_ASGN: begin alone = K_ASGN; eqk = K_EQ; end
			S_BAND: begin alone = K_BAND; dch = "&"; dk = K_LAND; has_eq = 0; end
			default: begin alone = K_BOR; dch = "|"; dk = K_LOR; has_eq = 0; end
		endcase
	endtask

	task automatic begin_token(logic [7:0] c);
		sc_state = S_START;
		if (is_digit(c)) begin
			sc_acc = c - "0"; sc_state = S_INT;
		end else if (c == "_" || is_alpha(c)) begin
			sc_name = c; sc_count = 1; sc_state = S_IDENT;
		end else if (is_blank(c)) begin
			sc_state = S_BLANK;
		end else begin
			case (c)
				"'": sc_state = S_CHOPEN;
				"\"": sc_state = S_STR;
				"~": push_tok(K_TILDE, 0, 0, 0);
				"$": push_tok(K_DOLLAR, 0, 0, 0);
				"(": push_tok(K_LPAR, 0, 0, 0);
				")": push_tok(K_RPAR, 0, 0, 0);
				"[": push_tok(K_LBRK, 0, 0, 0);
				"]": push_tok(K_RBRK, 0, 0, 0);
				"{": push_tok(K_LBRC, 0, 0, 0);
				"}": push_tok(K_RBRC, 0, 0, 0);
				",": push_tok(K_COMMA, 0, 0, 0);
				";": push_tok(K_SEMI, 0, 0, 0);
				"?": push_tok(K_QUES, 0, 0, 0);
				":": push_tok(K_COLON, 0, 0, 0);
				"^": push_tok(K_XOR, 0, 0, 0);
				"+": sc_state = S_PLUS;
				"-": sc_state = S_SUBT;
				"!": sc_state = S_NOT;
				"*": sc_state = S_MUL;
				"/": sc_state = S_DIV;
				"%": sc_state = S_MOD;
				"<": sc_state = S_LT;
				">": sc_state = S_GT;
				"=": sc_state = S_ASGN;
				"&": sc_state = S_BAND;
				"|": sc_state = S_BOR;
				default: begin
					push_tok(K_ERROR, c, 0, 0);
					sc_err = 1;
				end
			endcase
		end
	endtask

	task automatic scan_byte(logic [7:0] c);
		logic [63:0] v;
		logic [6:0] alone, dk, eqk;
		logic [8:0] dch;
		bit has_eq;
		scan_st_t st;
		v = sc_acc;
		st = sc_state;
		case (st)
			S_START: begin_token(c);
			S_BLANK: if (!is_blank(c)) begin
				if (sc_blanks) push_tok(K_BLANK, 0, 0, 0);
				begin_token(c);
			end
			S_IDENT: if (c == "_" || is_alpha(c) || is_digit(c)) begin
				if (sc_count < NameKeep) sc_name |= 64'(c) << (8 * sc_count);
				if (sc_count < 255) sc_count++;
			end else begin
				push_ident();
				begin_token(c);
			end
			S_INT: begin
				if (is_digit(c)) sc_acc = v * 10 + (c - "0");
				else if (c == ".") sc_state = S_DBL;
				else if (c == "u") sc_state = S_UINT;
				else begin
					sc_state = S_START;
					if (c == "l") push_tok(K_LONGC, v, 0, 0);
					else if (c == "s") push_tok(K_SHORTC, v & 64'hffff, 0, 0);
					else if (c == "f") push_tok(K_FLOATC, 0, 0, 0);
					else if (c == "d") push_tok(K_DOUBLEC, 0, 0, 0);
					else begin
						push_tok(K_INTC, v & 64'hffffffff, 0, 0);
						begin_token(c);
					end
				end
			end
			S_UINT: begin
				sc_state = S_START;
				if (c == "l") push_tok(K_ULONGC, v, 0, 0);
				else if (c == "s") push_tok(K_USHORTC, v & 64'hffff, 0, 0);
				else begin
					push_tok(K_UINTC, v & 64'hffffffff, 0, 0);
					begin_token(c);
				end
			end
			S_DBL: if (!is_digit(c)) begin
				sc_state = S_START;
				if (c == "f") push_tok(K_FLOATC, 0, 0, 0);
				else begin
					push_tok(K_DOUBLEC, 0, 0, 0);
					begin_token(c);
				end
			end
			S_CHOPEN: if (c == "\\") sc_state = S_CHESC;
			else begin
				push_tok(K_CHARC, c, 0, 0);
				sc_state = S_CHSKIP;
			end
			S_CHESC: begin
				push_tok(K_CHARC, unescape(c), 0, 0);
				sc_state = S_CHSKIP;
			end
			S_CHSKIP: sc_state = S_START;
			S_STR: if (c == "\\") sc_state = S_STRESC;
			else if (c == "\"") begin
				push_tok(K_STRC, 0, 0, 1);
				sc_state = S_START;
			end else push_tok(K_STRC, c, 0, 0);
			S_STRESC: begin
				push_tok(K_STRC, unescape(c), 0, 0);
				sc_state = S_STR;
			end
			default: begin
				op_parts(st, alone, dch, dk, eqk, has_eq);
				sc_state = S_START;
				if ({1'b0, c} == dch) begin
					if (st == S_LT) sc_state = S_SL;
					else if (st == S_GT) sc_state = S_SR;
					else push_tok(dk, 0, 0, 0);
				end else if (c == "=" && has_eq) push_tok(eqk, 0, 0, 0);
				else begin
					push_tok(alone, 0, 0, 0);
					begin_token(c);
				end
			end
		endcase
	endtask

	task automatic flush_pending();
		logic [6:0] alone, dk, eqk;
		logic [8:0] dch;
		bit has_eq;
		case (sc_state)
			S_START, S_CHSKIP: ;
			S_BLANK: if (sc_blanks) push_tok(K_BLANK, 0, 0, 0);
			S_IDENT: push_ident();
			S_INT: push_tok(K_INTC, sc_acc & 64'hffffffff, 0, 0);
			S_UINT: push_tok(K_UINTC, sc_acc & 64'hffffffff, 0, 0);
			S_DBL: push_tok(K_DOUBLEC, 0, 0, 0);
			S_CHOPEN, S_CHESC: push_tok(K_ERROR, 0, 0, 0);
			S_STR, S_STRESC: push_tok(K_STRC, 0, 0, 1);
			default: begin
				op_parts(sc_state, alone, dch, dk, eqk, has_eq);
				push_tok(alone, 0, 0, 0);
			end
		endcase
	endtask

	task automatic clear_scanner();
		sc_state = S_START; sc_acc = 0; sc_name = 0; sc_count = 0; sc_err = 0;
	endtask

	task automatic predict_word(logic [7:0] c, logic lst);
		byte_toks.delete();
		if (!sc_err) scan_byte(c);
		if (lst) begin
			if (!sc_err) flush_pending();
			push_tok(K_END, 0, 0, 0);
			clear_scanner();
		end
		if (byte_toks.size() > 0) byte_toks[byte_toks.size() - 1].last = 1;
		foreach (byte_toks[i]) token_queue.insert(token_queue.size(), byte_toks[i]);
	endtask

	task automatic send_word(logic [7:0] c, logic lst);
		int gap;
		gap = $urandom_range(0, 11);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			s_axis_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= c;
		s_axis_tlast <= lst;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predict_word(c, lst);
	endtask

	task automatic send_text(string txt, bit terminate);
		for (int i = 0; i < txt.len(); i++)
			send_word(txt[i], terminate && i == txt.len() - 1);
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		while (token_queue.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_blanks(logic b);
		cfg_wr_en <= 1;
		cfg_wr_data <= b;
		@(posedge clk);
		cfg_wr_en <= 0;
		sc_blanks = b;
	endtask

	// receiver
	always @(posedge clk) begin
		token_t want;
		logic [6:0] got_kind;
		cycles++;
		if (m_axis_tvalid && m_axis_tready) begin
			rx_wait = $urandom_range(0, 11);
			got_kind = m_axis_tuser[6:0];
			if (token_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected token kind %0d value %h", got_kind,
						m_axis_tdata[63:0]);
			end else begin
				want = token_queue.pop_front();
				if (check_next && want.last) begin
					check_next = 0;
					if (want.kind != check_kind || want.value != check_value) begin
						mismatches++;
						if (mismatches <= 10)
							$display("table row: want %0d/%h predicted %0d/%h",
								check_kind, check_value, want.kind, want.value);
					end
				end
				if (got_kind != want.kind || m_axis_tdata[63:0] != want.value ||
						m_axis_tdata[71:64] != want.len || m_axis_tuser[7] != want.done ||
						m_axis_tlast != want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: want k%0d v%h n%0d d%0d l%0d got k%0d v%h n%0d d%0d l%0d",
							want.kind, want.value, want.len, want.done, want.last,
							got_kind, m_axis_tdata[63:0], m_axis_tdata[71:64],
							m_axis_tuser[7], m_axis_tlast);
				end
			end
		end
		if (hold_off) begin
			m_axis_tready <= 0;
		end else if (rx_wait > 0) begin
			m_axis_tready <= 0;
			rx_wait--;
		end else begin
			m_axis_tready <= 1;
		end
	end

	always @(posedge clk) begin
		if (cycles > 400000) begin
			$display("Verification failed");
			$finish;
		end
	end

	// directed table: bytes, last flag, and where obvious the final token of the byte
	stim_row_t dir_rows[] = '{
		'{8'h00, 1'b0, 1'b1, K_ERROR, 64'h0},
		'{8'hff, 1'b1, 1'b1, K_END, 64'h0},
		'{"\\", 1'b1, 1'b1, K_END, 64'h0},
		'{".", 1'b1, 1'b1, K_END, 64'h0},
		'{"(", 1'b0, 1'b1, K_LPAR, 64'h0},
		'{"$", 1'b0, 1'b1, K_DOLLAR, 64'h0},
		'{"9", 1'b0, 1'b0, 7'd0, 64'h0},
		'{"l", 1'b0, 1'b1, K_LONGC, 64'd9},
		'{"5", 1'b0, 1'b0, 7'd0, 64'h0},
		'{"u", 1'b0, 1'b0, 7'd0, 64'h0},
		'{"s", 1'b0, 1'b1, K_USHORTC, 64'd5},
		'{"'", 1'b0, 1'b0, 7'd0, 64'h0},
		'{"\\", 1'b0, 1'b0, 7'd0, 64'h0},
		'{"n", 1'b0, 1'b1, K_CHARC, 64'd10},
		'{"'", 1'b0, 1'b0, 7'd0, 64'h0},
		'{"\"", 1'b0, 1'b0, 7'd0, 64'h0},
		'{"\\", 1'b0, 1'b0, 7'd0, 64'h0},
		'{"a", 1'b0, 1'b1, K_STRC, 64'd7},
		'{"\"", 1'b0, 1'b1, K_STRC, 64'h0},
		'{"<", 1'b0, 1'b0, 7'd0, 64'h0},
		'{"<", 1'b0, 1'b0, 7'd0, 64'h0},
		'{"=", 1'b0, 1'b1, K_SHLEQ, 64'h0},
		'{"'", 1'b1, 1'b1, K_END, 64'h0}
	};

	string snippets[] = '{
		"int x = 42u;", "unsigned long y;", "if (a<=b) a+=1; else b--;",
		"for (i=0;i<9;i++) {}", "while(p&&q||!r) x>>=2;", "return 'a';",
		"printf(\"hi\\tthere\");", "3.14f 2.5 7d 8f", "continue; break;",
		"switch (c) { case 1: x%=3; }", "NULL != ptr ^ ~m", "x*=y/=z-=1",
		"char c = '\\r';", "double signed short void const scanf do",
		"verylongidentifier_123 _a", "99999999999999999999999 18446744073709551617ul",
		"a>b>=c<<d>>e?f:g", "arr[3] = x & y | z;", "65535us 70000s 4294967296u"
	};

	initial begin
		string txt;
		int n, k;
		logic [7:0] c;
		sc_blanks = 0;
		clear_scanner();
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			check_next = dir_rows[i].chk;
			check_kind = dir_rows[i].kind;
			check_value = dir_rows[i].value;
			send_word(dir_rows[i].ch, dir_rows[i].lst);
			if (check_next && token_queue.size() > 0) begin
				s_axis_tvalid <= 0;
				while (check_next && token_queue.size() > 0) @(posedge clk);
			end
			check_next = 0;
		end
		send_text("int ", 1);
		send_text("\"ab", 1);
		send_text("12u", 1);
		send_text(">", 1);
		drain();
		write_blanks(1);
		send_text("a  \t\n b", 1);
		send_text("  ", 1);

		// long receiver stall while the sender keeps going
		fork
			begin
				hold_off = 1;
				repeat (300) @(posedge clk);
				hold_off = 0;
			end
			send_text("x = (a + b) ; y -= 3 ;", 1);
		join

		n = 0;
		while (n < 200) begin
			if (n == 100) begin
				drain();
				write_blanks(0);
			end
			if ($urandom_range(0, 4) != 0) begin
				txt = snippets[$urandom_range(0, snippets.size() - 1)];
				for (int i = 0; i < txt.len(); i++) begin
					c = txt[i];
					if ($urandom_range(0, 40) == 0) c = 8'($urandom_range(0, 255));
					send_word(c, i == txt.len() - 1 && $urandom_range(0, 1));
					n++;
				end
			end else begin
				k = $urandom_range(1, 8);
				for (int i = 0; i < k; i++) begin
					send_word(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
					n++;
				end
			end
		end
		send_word(" ", 1);
		drain();
		write_blanks(1);
		send_text("a b  ", 1);
		drain();
		if (mismatches == 0 && token_queue.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
